### hw/rtl/matrix3_inverse_unit_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef MATRIX3_INVERSE_UNIT_DEFINES_SVH
`define MATRIX3_INVERSE_UNIT_DEFINES_SVH

// Implication checked in the same cycle.
`define M3I_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the following cycle.
`define M3I_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/m3i_pkg.sv
package m3i_pkg;

    // Entry format
    localparam int EW  = 32;
    localparam int FB  = 16;
    // Cofactor, partial product, determinant, numerator, remainder widths
    localparam int CW  = 2 * EW + 1;
    localparam int PPW = 2 * EW + 1;
    localparam int DW  = 3 * EW + 3;
    localparam int NW  = CW + 2 * FB;
    localparam int RW  = DW + EW;
    localparam int NE  = 9;

    localparam logic [EW-1:0] ENTRY_MAX = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] ENTRY_MIN = {1'b1, {(EW-1){1'b0}}};

    typedef logic signed [EW-1:0]  t_entry;
    typedef logic signed [CW-1:0]  t_cof;
    typedef logic signed [2*EW-1:0] t_prod;
    typedef logic signed [PPW-1:0] t_pprod;
    typedef logic signed [DW-1:0]  t_det;
    typedef logic [NW-1:0]         t_num;
    typedef logic [RW-1:0]         t_rem;
    typedef logic [EW-1:0]         t_quo;

    typedef t_entry t_entry_arr [NE];
    typedef t_entry t_pivot_arr [3];
    typedef t_cof   t_cof_arr   [NE];
    typedef t_num   t_num_arr   [NE];
    typedef t_quo   t_quo_arr   [NE];

    // cofactor k = m[a]*m[b] - m[c]*m[d], index = column*3 + row
    localparam logic [3:0] COF_IDX [NE][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd7, 4'd2, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd6, 4'd5, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd6, 4'd2}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

endpackage

### hw/rtl/matrix3_inverse_unit.sv
// Channel  | Handshake           | Payload
// request  | i_valid / o_ready   | i_in_cC_rR (9 x Q16.16)
// result   | o_valid / i_ready   | o_out_cC_rR (9 x Q16.16), o_singular, o_overflowed
//
// One matrix per cycle sustained while i_ready holds; the path from accept to o_valid:
// 2 cofactor stages, 3 determinant stages, 1 divider setup stage, 32 quotient
// stages (one restoring step per quotient bit), 1 output register.
// Reset (synchronous, i_rst_n low) clears only the stage valid bits.
// A stalled result stalls only the stages behind it; empty stages keep filling.
`include "matrix3_inverse_unit_defines.svh"

module matrix3_inverse_unit import m3i_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_entry i_in_c0_r0,
    input  t_entry i_in_c0_r1,
    input  t_entry i_in_c0_r2,
    input  t_entry i_in_c1_r0,
    input  t_entry i_in_c1_r1,
    input  t_entry i_in_c1_r2,
    input  t_entry i_in_c2_r0,
    input  t_entry i_in_c2_r1,
    input  t_entry i_in_c2_r2,
    output logic   o_valid,
    input  logic   i_ready,
    output t_entry o_out_c0_r0,
    output t_entry o_out_c0_r1,
    output t_entry o_out_c0_r2,
    output t_entry o_out_c1_r0,
    output t_entry o_out_c1_r1,
    output t_entry o_out_c1_r2,
    output t_entry o_out_c2_r0,
    output t_entry o_out_c2_r1,
    output t_entry o_out_c2_r2,
    output logic   o_singular,
    output logic   o_overflowed
);

    t_entry_arr    m;
    logic          cof_valid, cof_ready;
    t_cof_arr      cof;
    t_pivot_arr    pivot;
    logic          det_valid, det_ready;
    logic [DW-1:0] dmag;
    logic          det_zero;
    t_num_arr      num;
    logic [NE-1:0] qneg;
    logic          div_valid, div_ready;
    t_quo_arr      quo;
    logic [NE-1:0] big, neg;
    logic          div_zero;
    logic          en_out;
    logic          r_ov;
    t_quo_arr      r_out;
    logic          r_sing, r_ovf;
    t_quo_arr      n_out;
    logic [NE-1:0] n_sat;

    assign m = '{i_in_c0_r0, i_in_c0_r1, i_in_c0_r2, i_in_c1_r0, i_in_c1_r1,
                 i_in_c1_r2, i_in_c2_r0, i_in_c2_r1, i_in_c2_r2};

    m3i_cofactor u_cof (
        .i_clk, .i_rst_n,
        .i_valid (i_valid),   .o_ready (o_ready),   .i_m (m),
        .o_valid (cof_valid), .i_ready (cof_ready), .o_cof (cof), .o_pivot (pivot)
    );

    m3i_determinant u_det (
        .i_clk, .i_rst_n,
        .i_valid (cof_valid), .o_ready (cof_ready), .i_cof (cof), .i_pivot (pivot),
        .o_valid (det_valid), .i_ready (det_ready), .o_dmag (dmag), .o_zero (det_zero),
        .o_num (num), .o_neg (qneg)
    );

    m3i_divider u_div (
        .i_clk, .i_rst_n,
        .i_valid (det_valid), .o_ready (det_ready), .i_dmag (dmag), .i_zero (det_zero),
        .i_num (num), .i_neg (qneg),
        .o_valid (div_valid), .i_ready (div_ready), .o_q (quo), .o_big (big),
        .o_neg (neg), .o_zero (div_zero)
    );

    assign en_out    = !r_ov || i_ready;
    assign div_ready = en_out;

    // Saturate, apply sign, zero out a singular matrix
    always_comb begin
        for (int k = 0; k < NE; k++) begin
            n_sat[k] = big[k] || (quo[k][EW-1] && (!neg[k] || (quo[k][EW-2:0] != '0)));
            if (div_zero) begin
                n_out[k] = '0;
            end else if (neg[k]) begin
                n_out[k] = -(n_sat[k] ? ENTRY_MIN : quo[k]);
            end else begin
                n_out[k] = n_sat[k] ? ENTRY_MAX : quo[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_out) begin
            r_ov <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out  <= n_out;
            r_sing <= div_zero;
            r_ovf  <= !div_zero && (n_sat != '0);
        end
    end

    assign o_valid      = r_ov;
    assign o_singular   = r_sing;
    assign o_overflowed = r_ovf;
    assign o_out_c0_r0  = r_out[0];
    assign o_out_c0_r1  = r_out[1];
    assign o_out_c0_r2  = r_out[2];
    assign o_out_c1_r0  = r_out[3];
    assign o_out_c1_r1  = r_out[4];
    assign o_out_c1_r2  = r_out[5];
    assign o_out_c2_r0  = r_out[6];
    assign o_out_c2_r1  = r_out[7];
    assign o_out_c2_r2  = r_out[8];

    // A singular result carries no overflow and zero diagonal entries
    `M3I_ASSERT_NOW(a_singular_zero, i_clk, i_rst_n, o_valid && o_singular,
        !o_overflowed && o_out_c0_r0 == '0 && o_out_c1_r1 == '0 && o_out_c2_r2 == '0,
        "singular result with nonzero data")

    // Input back-pressure only when a result is stalled at the output
    `M3I_ASSERT_NOW(a_stall_source, i_clk, i_rst_n, !o_ready,
        o_valid && !i_ready, "input stalled without output stall")

    // Overflow means at least one entry sits at a rail
    `M3I_ASSERT_NOW(a_ovf_rail, i_clk, i_rst_n, o_valid && o_overflowed,
        r_out[0] == ENTRY_MAX || r_out[0] == ENTRY_MIN || r_out[1] == ENTRY_MAX ||
        r_out[1] == ENTRY_MIN || r_out[2] == ENTRY_MAX || r_out[2] == ENTRY_MIN ||
        r_out[3] == ENTRY_MAX || r_out[3] == ENTRY_MIN || r_out[4] == ENTRY_MAX ||
        r_out[4] == ENTRY_MIN || r_out[5] == ENTRY_MAX || r_out[5] == ENTRY_MIN ||
        r_out[6] == ENTRY_MAX || r_out[6] == ENTRY_MIN || r_out[7] == ENTRY_MAX ||
        r_out[7] == ENTRY_MIN || r_out[8] == ENTRY_MAX || r_out[8] == ENTRY_MIN,
        "overflow flagged without saturated entry")

endmodule

### hw/rtl/m3i_cofactor.sv
module m3i_cofactor import m3i_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_entry_arr i_m,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cof_arr   o_cof,
    output t_pivot_arr o_pivot
);

    logic       r_v1, r_v2;
    logic       en1, en2;
    t_prod      r_pa [NE];
    t_prod      r_pb [NE];
    t_pivot_arr r_piv1, r_piv2;
    t_cof_arr   r_cof;

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;
    assign o_cof   = r_cof;
    assign o_pivot = r_piv2;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    // Stage 1: the eighteen entry products
    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int k = 0; k < NE; k++) begin
                r_pa[k] <= i_m[COF_IDX[k][0]] * i_m[COF_IDX[k][1]];
                r_pb[k] <= i_m[COF_IDX[k][2]] * i_m[COF_IDX[k][3]];
            end
            for (int j = 0; j < 3; j++) r_piv1[j] <= i_m[3*j];
        end
    end

    // Stage 2: cofactor differences
    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int k = 0; k < NE; k++) r_cof[k] <= CW'(r_pa[k]) - CW'(r_pb[k]);
            r_piv2 <= r_piv1;
        end
    end

endmodule

### hw/rtl/m3i_determinant.sv
module m3i_determinant import m3i_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_cof_arr   i_cof,
    input  t_pivot_arr i_pivot,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [DW-1:0] o_dmag,
    output logic       o_zero,
    output t_num_arr   o_num,
    output logic [NE-1:0] o_neg
);

    logic        r_v3, r_v4, r_v5;
    logic        en3, en4, en5;
    t_pprod      r_plo [3];
    t_pprod      r_phi [3];
    t_cof_arr    r_cof3, r_cof4;
    t_det        r_det;
    t_det        n_det;
    logic [DW-1:0] r_dmag;
    logic        r_zero;
    t_num_arr    r_num;
    logic [NE-1:0] r_neg;

    assign en5     = !r_v5 || i_ready;
    assign en4     = !r_v4 || en5;
    assign en3     = !r_v3 || en4;
    assign o_ready = en3;
    assign o_valid = r_v5;
    assign o_dmag  = r_dmag;
    assign o_zero  = r_zero;
    assign o_num   = r_num;
    assign o_neg   = r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en3) r_v3 <= i_valid;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // Stage 3: pivot times cofactor, cofactor split in a low and a high half
    always_ff @(posedge i_clk) begin
        if (en3) begin
            for (int j = 0; j < 3; j++) begin
                r_plo[j] <= i_pivot[j] * $signed({1'b0, i_cof[j][EW-1:0]});
                r_phi[j] <= i_pivot[j] * $signed(i_cof[j][CW-1:EW]);
            end
            r_cof3 <= i_cof;
        end
    end

    // Stage 4: recombine the halves and sum the three terms
    always_comb begin
        n_det = '0;
        for (int j = 0; j < 3; j++) begin
            n_det = n_det + (DW'(r_phi[j]) <<< EW) + DW'(r_plo[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_det  <= n_det;
            r_cof4 <= r_cof3;
        end
    end

    // Stage 5: magnitudes, quotient signs and scaled numerators
    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_dmag <= r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
            r_zero <= (r_det == '0);
            for (int k = 0; k < NE; k++) begin
                r_num[k] <= {(r_cof4[k][CW-1] ? CW'(-r_cof4[k]) : CW'(r_cof4[k])),
                             {(2*FB){1'b0}}};
                r_neg[k] <= r_cof4[k][CW-1] ^ r_det[DW-1];
            end
        end
    end

endmodule

### hw/rtl/m3i_divider.sv
module m3i_divider import m3i_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [DW-1:0] i_dmag,
    input  logic          i_zero,
    input  t_num_arr      i_num,
    input  logic [NE-1:0] i_neg,
    output logic          o_valid,
    input  logic          i_ready,
    output t_quo_arr      o_q,
    output logic [NE-1:0] o_big,
    output logic [NE-1:0] o_neg,
    output logic          o_zero
);

    // Stage 0 sets up, stages 1..EW each resolve one quotient bit, MSB first
    logic [EW:0]   r_v;
    logic [EW+1:0] en;
    logic [NE-1:0] r_big  [EW+1];
    logic [NE-1:0] r_neg  [EW+1];
    logic          r_zero [EW+1];
    t_rem          r_rem  [EW][NE];
    t_rem          r_ds   [EW][NE];
    t_quo          r_q    [1:EW][NE];

    assign en[EW+1] = i_ready;
    assign o_ready  = en[0];
    assign o_valid  = r_v[EW];
    assign o_q      = r_q[EW];
    assign o_big    = r_big[EW];
    assign o_neg    = r_neg[EW];
    assign o_zero   = r_zero[EW];

    // Ready ripples back through empty stages
    for (genvar s = 0; s <= EW; s++) begin : g_en
        assign en[s] = !r_v[s] || en[s+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int s = 1; s <= EW; s++) begin
                if (en[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    // Setup: quotient of EW+1 or more bits saturates anyway
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int k = 0; k < NE; k++) begin
                r_big[0][k] <= RW'(i_num[k]) >= {i_dmag, {EW{1'b0}}};
                r_rem[0][k] <= RW'(i_num[k]);
                r_ds[0][k]  <= RW'(i_dmag) << (EW - 1);
            end
            r_neg[0]  <= i_neg;
            r_zero[0] <= i_zero;
        end
    end

    // Restoring division steps
    for (genvar s = 1; s <= EW; s++) begin : g_step
        logic [NE-1:0] ge;
        always_comb begin
            for (int k = 0; k < NE; k++) ge[k] = r_rem[s-1][k] >= r_ds[s-1][k];
        end

        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_big[s]  <= r_big[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_zero[s] <= r_zero[s-1];
            end
        end

        // Quotient bits shift in from the right
        if (s == 1) begin : g_q_first
            always_ff @(posedge i_clk) begin
                if (en[s]) begin
                    for (int k = 0; k < NE; k++) r_q[s][k] <= EW'(ge[k]);
                end
            end
        end else begin : g_q_next
            always_ff @(posedge i_clk) begin
                if (en[s]) begin
                    for (int k = 0; k < NE; k++) r_q[s][k] <= {r_q[s-1][k][EW-2:0], ge[k]};
                end
            end
        end

        if (s < EW) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (en[s]) begin
                    for (int k = 0; k < NE; k++) begin
                        r_rem[s][k] <= ge[k] ? r_rem[s-1][k] - r_ds[s-1][k]
                                             : r_rem[s-1][k];
                        r_ds[s][k]  <= r_ds[s-1][k] >> 1;
                    end
                end
            end
        end
    end

endmodule

### tb/matrix3_inverse_checker.sv
`timescale 1ns / 1ps

module matrix3_inverse_checker import m3i_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  logic   i_o_ready,
    input  t_entry i_in [NE],
    input  logic   i_o_valid,
    input  logic   i_ready,
    input  t_entry i_out [NE],
    input  logic   i_singular,
    input  logic   i_overflowed,
    output int     o_fail_count,
    output int     o_pending
);

    typedef struct packed {
        logic [NE-1:0][EW-1:0] ent;
        logic                  sing;
        logic                  ovf;
    } inverse_t;

    inverse_t expected_inverses[$];

    // exact adjugate / determinant, truncating divide, saturate
    function automatic inverse_t invert3(t_entry_arr m);
        logic signed [127:0] w [NE];
        logic signed [127:0] cof [NE];
        logic signed [127:0] det;
        logic [127:0] dmag, num, q, lim;
        logic [EW-1:0] v;
        logic dneg, neg;
        inverse_t r;
        r = '0;
        for (int k = 0; k < NE; k++) w[k] = m[k];
        for (int k = 0; k < NE; k++)
            cof[k] = w[COF_IDX[k][0]] * w[COF_IDX[k][1]]
                   - w[COF_IDX[k][2]] * w[COF_IDX[k][3]];
        det = w[0] * cof[0] + w[3] * cof[1] + w[6] * cof[2];
        if (det == 0) begin
            r.sing = 1'b1;
            return r;
        end
        dneg = det[127];
        dmag = dneg ? -det : det;
        for (int k = 0; k < NE; k++) begin
            neg = cof[k][127] ^ dneg;
            num = cof[k][127] ? -cof[k] : cof[k];
            num = num << (2 * FB);
            q   = num / dmag;
            lim = neg ? (128'd1 << (EW - 1)) : ((128'd1 << (EW - 1)) - 1);
            if (q > lim) begin
                r.ovf = 1'b1;
                v = lim[EW-1:0];
            end else begin
                v = q[EW-1:0];
            end
            r.ent[k] = neg ? -v : v;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [EW-1:0] got, logic [EW-1:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    assign o_pending = expected_inverses.size();

    // predict on each accepted request, compare on each accepted result
    always @(posedge i_clk) begin
        inverse_t exp_r;
        t_entry_arr req;
        if (i_rst_n) begin
            if (i_valid && i_o_ready) begin
                for (int k = 0; k < NE; k++) req[k] = i_in[k];
                expected_inverses.push_back(invert3(req));
            end
            if (i_o_valid && i_ready) begin
                if (expected_inverses.size() == 0) begin
                    report_mismatch("unexpected result", '0, '0);
                end else begin
                    exp_r = expected_inverses.pop_front();
                    for (int k = 0; k < NE; k++)
                        if (i_out[k] !== exp_r.ent[k])
                            report_mismatch($sformatf("entry c%0d_r%0d", k / 3, k % 3),
                                            i_out[k], exp_r.ent[k]);
                    if (i_singular !== exp_r.sing)
                        report_mismatch("singular", i_singular, exp_r.sing);
                    if (i_overflowed !== exp_r.ovf)
                        report_mismatch("overflowed", i_overflowed, exp_r.ovf);
                end
            end
        end
    end

endmodule

### tb/tb_matrix3_inverse_unit.sv
`timescale 1ns / 1ps

module tb_matrix3_inverse_unit import m3i_pkg::*;;

    localparam int RANDOM_ITEMS   = 600;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam t_entry ONE        = 32'sh0001_0000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   i_ready = 1'b0;
    logic   o_ready, o_valid, o_singular, o_overflowed;
    t_entry req_m [NE];
    t_entry res_m [NE];
    int     fail_count, pending;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     idle_cycles = 0;

    initial for (int k = 0; k < NE; k++) req_m[k] = '0;

    always #5 i_clk = ~i_clk;

    matrix3_inverse_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_in_c0_r0(req_m[0]), .i_in_c0_r1(req_m[1]), .i_in_c0_r2(req_m[2]),
        .i_in_c1_r0(req_m[3]), .i_in_c1_r1(req_m[4]), .i_in_c1_r2(req_m[5]),
        .i_in_c2_r0(req_m[6]), .i_in_c2_r1(req_m[7]), .i_in_c2_r2(req_m[8]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_out_c0_r0(res_m[0]), .o_out_c0_r1(res_m[1]), .o_out_c0_r2(res_m[2]),
        .o_out_c1_r0(res_m[3]), .o_out_c1_r1(res_m[4]), .o_out_c1_r2(res_m[5]),
        .o_out_c2_r0(res_m[6]), .o_out_c2_r1(res_m[7]), .o_out_c2_r2(res_m[8]),
        .o_singular(o_singular), .o_overflowed(o_overflowed)
    );

    matrix3_inverse_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_o_ready(o_ready),
        .i_in(req_m), .i_o_valid(o_valid), .i_ready(i_ready), .i_out(res_m),
        .i_singular(o_singular), .i_overflowed(o_overflowed),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // result-side backpressure
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // idle cycle by cycle, then hold request until taken;
    // o_ready is sampled at negedge, stable to the edge
    task automatic send_matrix(t_entry_arr m);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        for (int k = 0; k < NE; k++) req_m[k] <= m[k];
        do begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic t_entry rand_entry(int style);
        case (style)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
            default: return $signed($urandom_range(0, 255)) - 128;
        endcase
    endfunction

    // random matrix of a few shapes: full range, moderate, tiny, singular
    function automatic t_entry_arr rand_matrix();
        t_entry_arr m;
        int shape, style;
        shape = $urandom_range(0, 9);
        style = (shape < 3) ? 0 : (shape < 8) ? 1 : 2;
        for (int k = 0; k < NE; k++) m[k] = rand_entry(style);
        if (shape == 7) begin
            for (int k = 0; k < NE; k++) if (k % 4 == 0) m[k] += 32'sh0004_0000;
        end
        if (shape == 9) begin
            for (int r = 0; r < 3; r++) m[6 + r] = m[r];
        end
        return m;
    endfunction

    function automatic t_entry_arr diag_matrix(t_entry a, t_entry b, t_entry c);
        t_entry_arr m;
        for (int k = 0; k < NE; k++) m[k] = '0;
        m[0] = a;
        m[4] = b;
        m[8] = c;
        return m;
    endfunction

    function automatic t_entry_arr fill_matrix(t_entry v);
        t_entry_arr m;
        for (int k = 0; k < NE; k++) m[k] = v;
        return m;
    endfunction

    initial begin
        t_entry_arr m;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity, zero, extremes, overflow, negative determinant
        send_idle_pct = 36;
        recv_idle_pct = 83;
        send_matrix(diag_matrix(ONE, ONE, ONE));
        send_matrix(diag_matrix(-ONE, ONE, ONE));
        send_matrix(diag_matrix(2 * ONE, ONE / 2, -4 * ONE));
        send_matrix(fill_matrix('0));
        send_matrix(fill_matrix(ONE));
        send_matrix(fill_matrix(ENTRY_MAX));
        send_matrix(fill_matrix(ENTRY_MIN));
        send_matrix(fill_matrix(-1));
        send_matrix(diag_matrix(1, 1, 1));
        send_matrix(diag_matrix(-1, 1, 1));
        send_matrix(diag_matrix(ENTRY_MAX, ENTRY_MAX, ENTRY_MAX));
        send_matrix(diag_matrix(ENTRY_MIN, ENTRY_MIN, ENTRY_MIN));
        send_matrix(diag_matrix(ENTRY_MIN, ENTRY_MAX, -1));
        send_matrix(diag_matrix(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000));
        send_matrix(diag_matrix(32'sh0000_0200, ONE, ONE));
        send_matrix(diag_matrix(ONE, ONE, 0));
        m = diag_matrix(ONE, ONE, ONE);
        m[3] = ENTRY_MAX;
        m[6] = ENTRY_MIN;
        m[7] = 32'sh5555_5555;
        send_matrix(m);
        m = fill_matrix(32'shAAAA_AAAA);
        m[0] = 32'sh5555_5555;
        m[4] = 32'sh5555_5555;
        send_matrix(m);

        // random, three idle profiles; drain at each profile change
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                drain_results();
                send_idle_pct = 83;
                recv_idle_pct = 36;
            end else if (i == 2 * RANDOM_ITEMS / 3) begin
                drain_results();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_matrix(rand_matrix());
        end

        drain_results();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/m3i_pkg.sv
hw/rtl/m3i_cofactor.sv
hw/rtl/m3i_determinant.sv
hw/rtl/m3i_divider.sv
hw/rtl/matrix3_inverse_unit.sv
tb/matrix3_inverse_checker.sv
tb/tb_matrix3_inverse_unit.sv
